>>> rtl/dttp_pkg.sv
// Package with the phase encoding, character codes and range limits of the date/time parser.
`timescale 1ns / 1ps

package dttp_pkg;

    // Parse phase, one-hot encoded.
    typedef enum logic [8:0] {
        PH_IDLE    = 9'b0_0000_0001,
        PH_MONTH   = 9'b0_0000_0010,
        PH_DAY     = 9'b0_0000_0100,
        PH_YEAR    = 9'b0_0000_1000,
        PH_HOUR    = 9'b0_0001_0000,
        PH_MINUTE  = 9'b0_0010_0000,
        PH_SECOND  = 9'b0_0100_0000,
        PH_MERID   = 9'b0_1000_0000,
        PH_MSUFFIX = 9'b1_0000_0000
    } t_phase;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_M  = 8'h4D;
    localparam logic [7:0] CH_UP_P  = 8'h50;

    // Range limits and year and hour adjustments.
    localparam logic [7:0] MONTH_MAX   = 8'd12;
    localparam logic [7:0] DAY_MAX     = 8'd31;
    localparam logic [7:0] HOUR_MAX    = 8'd23;
    localparam logic [7:0] MINSEC_MAX  = 8'd59;
    localparam logic [7:0] YEAR_PIVOT  = 8'd80;
    localparam logic [7:0] YEAR_OFFSET = 8'd100;
    localparam logic [7:0] PM_OFFSET   = 8'd12;

endpackage

>>> rtl/date_time_text_parser.sv
// Top level of the date/time text parser: one character per transfer, one result per parse.
// A result is loaded into the output register when the character that ends the parse is
// accepted. Throughput: one character per cycle when not stalled; each character makes at
// most one multiply-by-ten accumulate or field update, plus a phase step. The input stalls
// only while a result waits. Reset (synchronous, active low) returns the parser to idle,
// clears all fields and empties the output register.
`timescale 1ns / 1ps

module date_time_text_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic [0:0]  s_axis_tuser,   // [0] start_req
    // Result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] month, [15:8] day, [23:16] year,
                                        // [31:24] hour, [39:32] minute, [47:40] second
    output logic [1:0]  m_axis_tuser    // [0] parse_error, [1] stop_unconsumed
);

    // Parser state.
    dttp_pkg::t_phase r_phase, n_phase;
    logic       r_seen, n_seen;
    logic [7:0] r_acc, n_acc;
    logic [7:0] r_month, n_month;
    logic [7:0] r_day, n_day;
    logic [7:0] r_year, n_year;
    logic [7:0] r_hour, n_hour;
    logic [7:0] r_minute, n_minute;
    logic [7:0] r_second, n_second;

    // Output register.
    logic        r_out_valid;
    logic [47:0] r_out_data;
    logic [1:0]  r_out_user;

    // Working values for this character.
    logic             accept;
    logic             start;
    logic [7:0]       ch;
    dttp_pkg::t_phase w_phase;
    logic             w_seen;
    logic [7:0]       w_acc;
    logic             is_digit;
    logic             num_char;
    logic [7:0]       acc_next;
    logic [7:0]       hour_pm;
    logic             fin;
    logic             fin_err;
    logic             fin_unc;

    // A new character is taken whenever the output register is free or being drained.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign start         = s_axis_tuser[0];
    assign ch            = s_axis_tdata;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Start clears the number in progress; the phase jumps to the month.
    assign w_phase  = start ? dttp_pkg::PH_MONTH : r_phase;
    assign w_seen   = start ? 1'b0 : r_seen;
    assign w_acc    = start ? 8'd0 : r_acc;

    // Number accumulation: leading spaces are skipped, digits accumulate modulo 256.
    assign is_digit = (ch >= dttp_pkg::CH_ZERO) && (ch <= dttp_pkg::CH_NINE);
    assign num_char = is_digit || (!w_seen && (ch == dttp_pkg::CH_SPACE));
    assign acc_next = {w_acc[4:0], 3'b000} + {w_acc[6:0], 1'b0} + (ch - dttp_pkg::CH_ZERO);

    // Next-state logic for one accepted character.
    always_comb begin
        n_phase  = w_phase;
        n_seen   = w_seen;
        n_acc    = w_acc;
        n_month  = start ? 8'd0 : r_month;
        n_day    = start ? 8'd0 : r_day;
        n_year   = start ? 8'd0 : r_year;
        n_hour   = start ? 8'd0 : r_hour;
        n_minute = start ? 8'd0 : r_minute;
        n_second = start ? 8'd0 : r_second;
        hour_pm  = n_hour + dttp_pkg::PM_OFFSET;
        fin      = 1'b0;
        fin_err  = 1'b0;
        fin_unc  = 1'b0;

        case (w_phase)
            dttp_pkg::PH_MONTH,
            dttp_pkg::PH_DAY,
            dttp_pkg::PH_YEAR,
            dttp_pkg::PH_HOUR,
            dttp_pkg::PH_MINUTE,
            dttp_pkg::PH_SECOND: begin
                if (num_char) begin
                    if (is_digit) begin
                        n_acc  = acc_next;
                        n_seen = 1'b1;
                    end
                end else begin
                    // The number ends here; the character is its delimiter.
                    n_acc  = 8'd0;
                    n_seen = 1'b0;
                    case (w_phase)
                        dttp_pkg::PH_MONTH: begin
                            n_month = w_acc;
                            if (w_acc > dttp_pkg::MONTH_MAX || ch != dttp_pkg::CH_SLASH) begin
                                fin     = 1'b1;
                                fin_err = 1'b1;
                            end else begin
                                n_phase = dttp_pkg::PH_DAY;
                            end
                        end
                        dttp_pkg::PH_DAY: begin
                            n_day = w_acc;
                            if (w_acc > dttp_pkg::DAY_MAX || ch != dttp_pkg::CH_SLASH) begin
                                fin     = 1'b1;
                                fin_err = 1'b1;
                            end else begin
                                n_phase = dttp_pkg::PH_YEAR;
                            end
                        end
                        dttp_pkg::PH_YEAR: begin
                            n_year = (w_acc < dttp_pkg::YEAR_PIVOT) ?
                                     w_acc + dttp_pkg::YEAR_OFFSET : w_acc;
                            if (ch == dttp_pkg::CH_NUL || ch == dttp_pkg::CH_COMMA) begin
                                fin     = 1'b1;
                                fin_unc = 1'b1;
                            end else if (ch != dttp_pkg::CH_SPACE) begin
                                fin     = 1'b1;
                                fin_err = 1'b1;
                            end else begin
                                n_phase = dttp_pkg::PH_HOUR;
                            end
                        end
                        dttp_pkg::PH_HOUR: begin
                            n_hour = w_acc;
                            if (w_acc > dttp_pkg::HOUR_MAX ||
                                (ch != dttp_pkg::CH_COLON && ch != dttp_pkg::CH_DOT)) begin
                                fin     = 1'b1;
                                fin_err = 1'b1;
                            end else begin
                                n_phase = dttp_pkg::PH_MINUTE;
                            end
                        end
                        dttp_pkg::PH_MINUTE: begin
                            n_minute = w_acc;
                            if (w_acc > dttp_pkg::MINSEC_MAX) begin
                                fin     = 1'b1;
                                fin_err = 1'b1;
                            end else if (ch == dttp_pkg::CH_COLON || ch == dttp_pkg::CH_DOT) begin
                                n_phase = dttp_pkg::PH_SECOND;
                            end else if (ch == dttp_pkg::CH_SPACE) begin
                                n_phase = dttp_pkg::PH_MERID;
                            end else if (ch == dttp_pkg::CH_COMMA || ch == dttp_pkg::CH_NUL) begin
                                fin     = 1'b1;
                                fin_unc = 1'b1;
                            end else begin
                                fin     = 1'b1;
                                fin_err = 1'b1;
                            end
                        end
                        default: begin
                            // Seconds field.
                            n_second = w_acc;
                            if (w_acc > dttp_pkg::MINSEC_MAX || ch != dttp_pkg::CH_SPACE) begin
                                fin     = 1'b1;
                                fin_err = 1'b1;
                            end else begin
                                n_phase = dttp_pkg::PH_MERID;
                            end
                        end
                    endcase
                end
            end
            dttp_pkg::PH_MERID: begin
                // PM moves the hour to 24-hour form; the hour is then checked again.
                if (ch == dttp_pkg::CH_UP_P) begin
                    n_hour = hour_pm;
                    if (hour_pm > dttp_pkg::HOUR_MAX) begin
                        fin     = 1'b1;
                        fin_err = 1'b1;
                    end else begin
                        n_phase = dttp_pkg::PH_MSUFFIX;
                    end
                end else if (ch != dttp_pkg::CH_UP_A || n_hour > dttp_pkg::HOUR_MAX) begin
                    fin     = 1'b1;
                    fin_err = 1'b1;
                end else begin
                    n_phase = dttp_pkg::PH_MSUFFIX;
                end
            end
            dttp_pkg::PH_MSUFFIX: begin
                fin     = 1'b1;
                fin_err = (ch != dttp_pkg::CH_UP_M);
            end
            default: begin
                // Idle, and any code without meaning, ignores the character.
                n_phase = dttp_pkg::PH_IDLE;
            end
        endcase

        if (fin) begin
            n_phase = dttp_pkg::PH_IDLE;
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= dttp_pkg::PH_IDLE;
            r_seen   <= 1'b0;
            r_acc    <= 8'd0;
            r_month  <= 8'd0;
            r_day    <= 8'd0;
            r_year   <= 8'd0;
            r_hour   <= 8'd0;
            r_minute <= 8'd0;
            r_second <= 8'd0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_seen   <= n_seen;
            r_acc    <= n_acc;
            r_month  <= n_month;
            r_day    <= n_day;
            r_year   <= n_year;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
        end
    end

    // Output register valid flag: set by a finishing character, cleared by a result transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && fin) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload, loaded when a parse ends.
    always_ff @(posedge i_clk) begin
        if (accept && fin) begin
            r_out_data <= {n_second, n_minute, n_hour, n_year, n_day, n_month};
            r_out_user <= {fin_unc, fin_err};
        end
    end

endmodule

>>> test/date_time_text_parser_tb.sv
// Self-checking testbench for the date/time text parser, with a scoreboard that predicts each result.
`timescale 1ns / 1ps

module date_time_text_parser_tb;

    // One parse result, split into its fields.
    typedef struct packed {
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] year;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
        logic       parse_error;
        logic       stop_unconsumed;
    } t_date_fields;

    // Tracks the parser state from the accepted characters and checks each result transfer.
    class t_date_scoreboard;
        dttp_pkg::t_phase phase;
        bit               digit_seen;
        logic [7:0]       accum;
        logic [7:0]       mon, dy, yr, hr, mi, se;
        t_date_fields     pending_q[$];
        int unsigned      mismatches;
        int unsigned      dates_started;
        int unsigned      results_seen;
        int unsigned      error_results;
        int unsigned      early_stops;

        function new();
            phase = dttp_pkg::PH_IDLE;
            clear_fields();
        endfunction

        function void clear_fields();
            digit_seen = 1'b0;
            accum = '0;
            mon = '0;
            dy = '0;
            yr = '0;
            hr = '0;
            mi = '0;
            se = '0;
        endfunction

        // Leading spaces and digits belong to the number; anything else ends it.
        function bit take_num(logic [7:0] c);
            if (!digit_seen && c == dttp_pkg::CH_SPACE) return 1'b1;
            if (c >= dttp_pkg::CH_ZERO && c <= dttp_pkg::CH_NINE) begin
                accum = accum * 8'd10 + (c - dttp_pkg::CH_ZERO);
                digit_seen = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function logic [7:0] close_num();
            logic [7:0] v;
            v = accum;
            accum = '0;
            digit_seen = 1'b0;
            return v;
        endfunction

        function void finish(bit err, bit unconsumed);
            pending_q.push_back('{mon, dy, yr, hr, mi, se, err, unconsumed});
            phase = dttp_pkg::PH_IDLE;
        endfunction

        // Notes one accepted character; returns 1 unless the parser simply ignored it.
        function bit note_char(bit start, logic [7:0] c);
            if (start) begin
                clear_fields();
                phase = dttp_pkg::PH_MONTH;
                dates_started++;
            end
            if (phase == dttp_pkg::PH_IDLE) return 1'b0;
            case (phase)
                dttp_pkg::PH_MONTH: begin
                    if (!take_num(c)) begin
                        mon = close_num();
                        if (mon > dttp_pkg::MONTH_MAX || c != dttp_pkg::CH_SLASH)
                            finish(1'b1, 1'b0);
                        else phase = dttp_pkg::PH_DAY;
                    end
                end
                dttp_pkg::PH_DAY: begin
                    if (!take_num(c)) begin
                        dy = close_num();
                        if (dy > dttp_pkg::DAY_MAX || c != dttp_pkg::CH_SLASH)
                            finish(1'b1, 1'b0);
                        else phase = dttp_pkg::PH_YEAR;
                    end
                end
                dttp_pkg::PH_YEAR: begin
                    if (!take_num(c)) begin
                        yr = close_num();
                        if (yr < dttp_pkg::YEAR_PIVOT) yr = yr + dttp_pkg::YEAR_OFFSET;
                        if (c == dttp_pkg::CH_NUL || c == dttp_pkg::CH_COMMA)
                            finish(1'b0, 1'b1);
                        else if (c != dttp_pkg::CH_SPACE) finish(1'b1, 1'b0);
                        else phase = dttp_pkg::PH_HOUR;
                    end
                end
                dttp_pkg::PH_HOUR: begin
                    if (!take_num(c)) begin
                        hr = close_num();
                        if (hr > dttp_pkg::HOUR_MAX ||
                            (c != dttp_pkg::CH_COLON && c != dttp_pkg::CH_DOT))
                            finish(1'b1, 1'b0);
                        else phase = dttp_pkg::PH_MINUTE;
                    end
                end
                dttp_pkg::PH_MINUTE: begin
                    if (!take_num(c)) begin
                        mi = close_num();
                        if (mi > dttp_pkg::MINSEC_MAX) finish(1'b1, 1'b0);
                        else if (c == dttp_pkg::CH_COLON || c == dttp_pkg::CH_DOT)
                            phase = dttp_pkg::PH_SECOND;
                        else if (c == dttp_pkg::CH_SPACE) phase = dttp_pkg::PH_MERID;
                        else if (c == dttp_pkg::CH_COMMA || c == dttp_pkg::CH_NUL)
                            finish(1'b0, 1'b1);
                        else finish(1'b1, 1'b0);
                    end
                end
                dttp_pkg::PH_SECOND: begin
                    if (!take_num(c)) begin
                        se = close_num();
                        if (se > dttp_pkg::MINSEC_MAX || c != dttp_pkg::CH_SPACE)
                            finish(1'b1, 1'b0);
                        else phase = dttp_pkg::PH_MERID;
                    end
                end
                dttp_pkg::PH_MERID: begin
                    // PM shifts the hour, which must still be a valid 24-hour value.
                    if (c == dttp_pkg::CH_UP_P || c == dttp_pkg::CH_UP_A) begin
                        if (c == dttp_pkg::CH_UP_P) hr = hr + dttp_pkg::PM_OFFSET;
                        if (hr > dttp_pkg::HOUR_MAX) finish(1'b1, 1'b0);
                        else phase = dttp_pkg::PH_MSUFFIX;
                    end else begin
                        finish(1'b1, 1'b0);
                    end
                end
                dttp_pkg::PH_MSUFFIX: finish(c != dttp_pkg::CH_UP_M, 1'b0);
                default: phase = dttp_pkg::PH_IDLE;
            endcase
            return 1'b1;
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [47:0] d, logic [1:0] u);
            t_date_fields want;
            if (pending_q.size() == 0) begin
                $error("result transfer with no date pending: tdata=%h tuser=%b", d, u);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            results_seen++;
            if (want.parse_error) error_results++;
            if (want.stop_unconsumed) early_stops++;
            check_field("month", want.month, d[7:0]);
            check_field("day", want.day, d[15:8]);
            check_field("year", want.year, d[23:16]);
            check_field("hour", want.hour, d[31:24]);
            check_field("minute", want.minute, d[39:32]);
            check_field("second", want.second, d[47:40]);
            check_field("parse_error", 8'(want.parse_error), 8'(u[0]));
            check_field("stop_unconsumed", 8'(want.stop_unconsumed), 8'(u[1]));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] char_in
    logic [0:0]  s_axis_tuser;   // [0] start_req
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [7:0] month .. [47:40] second
    logic [1:0]  m_axis_tuser;   // [0] parse_error, [1] stop_unconsumed

    t_date_scoreboard sb;
    logic [7:0]       text_q[$];
    bit               calm;
    int unsigned      parsed_chars;

    date_time_text_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock with a 4 ns period.
    always #2 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void load_text(string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    // Appends a number: in range most of the time, else a boundary, a wrapping or an empty one.
    function automatic void put_num(int unsigned maxv, int unsigned alt);
        int unsigned v;
        int unsigned pick;
        int unsigned div;
        int unsigned n_sp;
        n_sp = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n_sp) text_q.push_back(dttp_pkg::CH_SPACE);
        pick = $urandom_range(0, 19);
        if (pick == 0) return;
        else if (pick < 12) v = $urandom_range(0, maxv);
        else if (pick == 12) v = maxv;
        else if (pick == 13) v = maxv + 1;
        else if (pick == 14) v = 0;
        else if (pick == 15) v = 255;
        else if (pick == 16) v = $urandom_range(256, 999);
        else if (pick == 17) v = alt;
        else v = $urandom_range(0, 999);
        if ($urandom_range(0, 7) == 0) text_q.push_back(dttp_pkg::CH_ZERO);
        div = (v >= 100) ? 100 : (v >= 10) ? 10 : 1;
        while (div > 0) begin
            text_q.push_back(8'(dttp_pkg::CH_ZERO + (v / div) % 10));
            div = div / 10;
        end
    endfunction

    // Appends the expected delimiter, or now and then a random byte.
    function automatic void put_delim(logic [7:0] good);
        if ($urandom_range(0, 24) == 0) text_q.push_back(8'($urandom_range(0, 255)));
        else text_q.push_back(good);
    endfunction

    function automatic logic [7:0] time_sep();
        return ($urandom_range(0, 1) == 0) ? dttp_pkg::CH_COLON : dttp_pkg::CH_DOT;
    endfunction

    // Drives one character and waits for its transfer, then sometimes idles for a while.
    task automatic send_char(bit start, logic [7:0] c);
        int unsigned gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        if (sb.note_char(start, c)) parsed_chars++;
        gap = calm ? 0 : gap_len();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Sends the buffered text as one date, the first character with the start flag.
    task automatic send_text();
        foreach (text_q[i]) send_char(i == 0, text_q[i]);
    endtask

    // Result side: random stalls on the ready signal.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 2) == 0) stall_left = gap_len();
            end
        end
    end

    // Every result transfer is checked against the oldest pending date.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Main sequence: reset, directed dates, then random dates mixed with noise.
    initial begin
        int unsigned sel;
        int unsigned cut;
        int unsigned n_noise;
        sb = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        calm = 1'b0;
        parsed_chars = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A stray character while idle is ignored.
        send_char(1'b0, "Q");
        // Date only, ended by NUL, with a year below the pivot.
        load_text("12/31/79");
        text_q.push_back(dttp_pkg::CH_NUL);
        send_text();
        // A new start abandons a parse; then empty numbers and a comma after the minutes.
        load_text("5/");
        send_text();
        load_text("//0 23:59,");
        send_text();
        // Month out of range.
        load_text("13/");
        send_text();

        while (parsed_chars < 1700) begin
            text_q.delete();
            put_num(12, 1);
            put_delim(dttp_pkg::CH_SLASH);
            put_num(31, 31);
            put_delim(dttp_pkg::CH_SLASH);
            put_num(99, 79 + $urandom_range(0, 1));
            sel = $urandom_range(0, 9);
            if (sel == 0) text_q.push_back(dttp_pkg::CH_NUL);
            else if (sel == 1) text_q.push_back(dttp_pkg::CH_COMMA);
            else if (sel == 2) text_q.push_back(8'($urandom_range(0, 255)));
            else begin
                text_q.push_back(dttp_pkg::CH_SPACE);
                put_num(23, 11 + $urandom_range(0, 1));
                put_delim(time_sep());
                put_num(59, 59);
                sel = $urandom_range(0, 9);
                if (sel == 0) text_q.push_back(dttp_pkg::CH_NUL);
                else if (sel == 1) text_q.push_back(dttp_pkg::CH_COMMA);
                else if (sel == 2) text_q.push_back(8'($urandom_range(0, 255)));
                else begin
                    if (sel < 6) begin
                        text_q.push_back(time_sep());
                        put_num(59, 60);
                    end
                    put_delim(dttp_pkg::CH_SPACE);
                    sel = $urandom_range(0, 9);
                    if (sel < 5) text_q.push_back(dttp_pkg::CH_UP_P);
                    else if (sel < 9) text_q.push_back(dttp_pkg::CH_UP_A);
                    else text_q.push_back(8'($urandom_range(0, 255)));
                    put_delim(dttp_pkg::CH_UP_M);
                end
            end
            // Some dates are cut short so that the next start finds the parser busy.
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, text_q.size());
                while (text_q.size() > cut) void'(text_q.pop_back());
            end
            calm = ($urandom_range(0, 3) == 0);
            send_text();
            // Random bytes without a start, mostly ignored.
            if ($urandom_range(0, 4) == 0) begin
                n_noise = $urandom_range(1, 4);
                repeat (n_noise) send_char(1'b0, 8'($urandom_range(0, 255)));
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        calm = 1'b1;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d dates and %0d parsed characters; %0d results checked.",
                 sb.dates_started, parsed_chars, sb.results_seen);
        $display("Of those results %0d flagged a format or range error and %0d stopped early.",
                 sb.error_results, sb.early_stops);
        if (sb.mismatches == 0) begin
            $display("date_time_text_parser_tb OK");
        end else begin
            $display("date_time_text_parser_tb NOT OK");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20_000_000;
        $display("date_time_text_parser_tb NOT OK");
        $finish;
    end

endmodule
